// File: sv/sqs_pkg.sv
// shared types and constants for the stack/queue statistics block
package sqs_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PIVOT,
      ST_INNER,
      ST_FINISH
   } sqs_state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_PUSH_BACK,
      CELL_POP,
      CELL_ROTATE
   } sqs_cell_op_type;

   typedef struct packed {
      sqs_cell_op_type    op;
      logic signed [31:0] value;
   } sqs_cell_ctl_type;

   typedef struct packed {
      logic               operation;
      logic signed [31:0] value;
   } sqs_req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic [1:0]         status;
      logic [4:0]         count;
      logic [4:0]         distinct;
      logic signed [31:0] smallest;
      logic signed [31:0] largest;
      logic signed [39:0] total;
   } sqs_rsp_type;

endpackage

// File: sv/sqs_cell.sv
// one storage cell of the element chain
module sqs_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  logic                      clock,
   input  sqs_pkg::sqs_cell_ctl_type ctl,
   input  logic [CW-1:0]             count,
   input  logic signed [31:0]        left_value,
   input  logic signed [31:0]        right_value,
   input  logic signed [31:0]        head_value,
   output logic signed [31:0]        value_out
);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         sqs_pkg::CELL_HOLD:       value_in = value_ff;
         sqs_pkg::CELL_PUSH_FRONT: value_in = (INDEX == 0) ? ctl.value : left_value;
         sqs_pkg::CELL_PUSH_BACK:  if (count == CW'(INDEX)) value_in = ctl.value;
         sqs_pkg::CELL_POP:        value_in = right_value;
         // wrap the first element around to the last occupied cell
         sqs_pkg::CELL_ROTATE:     value_in = (count == CW'(INDEX + 1)) ? head_value
                                                                        : right_value;
         default:                  value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

// File: sv/stack_queue_with_statistics.sv
// stack/queue of signed values with count, distinct, min, max and sum per request
// one request at a time: req_stall is held from acceptance until the response is issued,
// and while a response is stalled; the rescan
// rotates the cell chain count+1 times per stored element, pivot against later elements
// reset (synchronous, active high) empties the store, clears the sum and selects stack mode
// the cells themselves are not cleared; only occupied cells are ever read
module stack_queue_with_statistics #(
   parameter int DEPTH = sqs_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sqs_pkg::sqs_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sqs_pkg::sqs_rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   // mode register
   logic queue_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         queue_mode_ff <= csr_write_data;
      end
   end

   // control and statistics registers
   sqs_pkg::sqs_state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic signed [39:0] sum_ff, sum_in;
   logic signed [31:0] popped_ff, popped_in;
   logic [1:0]         status_ff, status_in;
   logic [CW-1:0]      pivot_idx_ff, pivot_idx_in;   // current pivot element
   logic [CW-1:0]      step_ff, step_in;             // rotation distance from pivot
   logic [CW-1:0]      distinct_ff, distinct_in;
   logic               uniq_ff, uniq_in;
   logic signed [31:0] pivot_ff, pivot_in;
   logic signed [31:0] min_ff, min_in;
   logic signed [31:0] max_ff, max_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sqs_pkg::sqs_rsp_type rsp_ff, rsp_in;

   logic accept;
   logic out_busy;
   logic in_range;

   // cell chain, cell 0 holds the head element whenever the block is idle
   sqs_pkg::sqs_cell_ctl_type cell_ctl;
   logic signed [31:0]        cell_value [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic signed [31:0] left_v;
      logic signed [31:0] right_v;
      if (k == 0) begin : g_first
         assign left_v = cell_value[0];
      end else begin : g_left
         assign left_v = cell_value[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
         assign right_v = cell_value[k];
      end else begin : g_right
         assign right_v = cell_value[k+1];
      end
      sqs_cell #(.INDEX(k), .CW(CW)) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .count       (count_ff),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (cell_value[0]),
         .value_out   (cell_value[k])
      );
   end

   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign req_stall = (state_ff != sqs_pkg::ST_IDLE) || out_busy;
   assign accept    = req_valid && !req_stall;
   // element at rotation distance step still lies after the pivot
   assign in_range  = ({1'b0, pivot_idx_ff} + {1'b0, step_ff}) < {1'b0, count_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      popped_in    = popped_ff;
      status_in    = status_ff;
      pivot_idx_in = pivot_idx_ff;
      step_in      = step_ff;
      distinct_in  = distinct_ff;
      uniq_in      = uniq_ff;
      pivot_in     = pivot_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cell_ctl.op    = sqs_pkg::CELL_HOLD;
      cell_ctl.value = req_data.value;

      case (state_ff)
         sqs_pkg::ST_IDLE: begin
            if (accept) begin
               popped_in = '0;
               status_in = sqs_pkg::STATUS_OK;
               if (req_data.operation == sqs_pkg::OP_PUSH) begin
                  if (count_ff == CW'(DEPTH)) begin
                     status_in = sqs_pkg::STATUS_FULL;
                  end else begin
                     cell_ctl.op = queue_mode_ff ? sqs_pkg::CELL_PUSH_BACK
                                                 : sqs_pkg::CELL_PUSH_FRONT;
                     count_in = count_ff + CW'(1);
                     sum_in   = sum_ff + {{8{req_data.value[31]}}, req_data.value};
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = sqs_pkg::STATUS_EMPTY;
                  end else begin
                     cell_ctl.op = sqs_pkg::CELL_POP;
                     popped_in   = cell_value[0];
                     count_in    = count_ff - CW'(1);
                     sum_in      = sum_ff - {{8{cell_value[0][31]}}, cell_value[0]};
                  end
               end
               pivot_idx_in = '0;
               distinct_in  = '0;
               min_in       = -32'sd1;
               max_in       = -32'sd1;
               state_in     = (count_in == '0) ? sqs_pkg::ST_FINISH : sqs_pkg::ST_PIVOT;
            end
         end

         sqs_pkg::ST_PIVOT: begin
            pivot_in = cell_value[0];
            if (pivot_idx_ff == '0 || cell_value[0] < min_ff) min_in = cell_value[0];
            if (pivot_idx_ff == '0 || cell_value[0] > max_ff) max_in = cell_value[0];
            uniq_in     = 1'b1;
            step_in     = CW'(1);
            cell_ctl.op = sqs_pkg::CELL_ROTATE;
            state_in    = sqs_pkg::ST_INNER;
         end

         sqs_pkg::ST_INNER: begin
            cell_ctl.op = sqs_pkg::CELL_ROTATE;
            if (in_range && cell_value[0] == pivot_ff) uniq_in = 1'b0;
            step_in = step_ff + CW'(1);
            // a full turn plus one leaves the next pivot at the head
            if (step_ff == count_ff) begin
               distinct_in  = distinct_ff + CW'(uniq_ff);
               pivot_idx_in = pivot_idx_ff + CW'(1);
               state_in     = (pivot_idx_ff + CW'(1) == count_ff) ? sqs_pkg::ST_FINISH
                                                                  : sqs_pkg::ST_PIVOT;
            end
         end

         sqs_pkg::ST_FINISH: begin
            if (!out_busy) begin
               rsp_in.popped_value = popped_ff;
               rsp_in.status       = status_ff;
               rsp_in.count        = 5'(count_ff);
               rsp_in.distinct     = 5'(distinct_ff);
               rsp_in.smallest     = min_ff;
               rsp_in.largest      = max_ff;
               rsp_in.total        = sum_ff;
               rsp_valid_in        = 1'b1;
               state_in            = sqs_pkg::ST_IDLE;
            end
         end

         default: state_in = sqs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sqs_pkg::ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      popped_ff    <= popped_in;
      status_ff    <= status_in;
      pivot_idx_ff <= pivot_idx_in;
      step_ff      <= step_in;
      distinct_ff  <= distinct_in;
      uniq_ff      <= uniq_in;
      pivot_ff     <= pivot_in;
      min_ff       <= min_in;
      max_ff       <= max_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an accepted request always starts a scan or a result
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != sqs_pkg::ST_IDLE)
      else $error("request accepted but block stayed idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count beyond depth");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == sqs_pkg::ST_FINISH)
      else $error("response raised outside finish state");

   a_pivot_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == sqs_pkg::ST_INNER |-> pivot_idx_ff < count_ff && step_ff <= count_ff)
      else $error("scan index out of range");

endmodule

// File: tb/testbench.sv
// testbench for the stack/queue statistics block: directed table, then random requests
`timescale 1ns / 1ps

module testbench;

   localparam int DEPTH = sqs_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_REQUESTS = 1700;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES = 300;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic                 csr_write_data = 1'b0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   sqs_pkg::sqs_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   sqs_pkg::sqs_rsp_type rsp_data;

   stack_queue_with_statistics #(.DEPTH(DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // predictor state: circular store with head pointer, modelling the block's cell chain
   logic signed [31:0] model_store [DEPTH];
   int                 model_head;
   int                 model_count;
   logic signed [39:0] model_sum;
   logic               model_queue_mode;

   sqs_pkg::sqs_rsp_type expected_rsp [$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          hold_receiver = 1'b0;

   // one directed row: request plus optional literal expectation
   typedef struct {
      logic        mode_write;
      logic        mode;
      sqs_pkg::sqs_req_type req;
      bit          literal;
      logic [1:0]  lit_status;
      logic [4:0]  lit_count;
      logic signed [31:0] lit_smallest;
   } directed_row_type;

   function automatic sqs_pkg::sqs_rsp_type predict_stack_queue(sqs_pkg::sqs_req_type req);
      sqs_pkg::sqs_rsp_type r;
      int          slot_i;
      int          slot_j;
      bit          seen;
      r = '0;
      r.status = sqs_pkg::STATUS_OK;
      if (req.operation == sqs_pkg::OP_PUSH) begin
         if (model_count >= DEPTH) begin
            r.status = sqs_pkg::STATUS_FULL;
         end else begin
            if (model_queue_mode) begin
               model_store[(model_head + model_count) % DEPTH] = req.value;
            end else begin
               model_head = (model_head + DEPTH - 1) % DEPTH;
               model_store[model_head] = req.value;
            end
            model_count++;
            model_sum = model_sum + 40'(req.value);
         end
      end else begin
         if (model_count == 0) begin
            r.status = sqs_pkg::STATUS_EMPTY;
         end else begin
            r.popped_value = model_store[model_head];
            model_head = (model_head + 1) % DEPTH;
            model_count--;
            model_sum = model_sum - 40'(r.popped_value);
         end
      end
      // rescan the occupied entries for distinct, min and max
      r.smallest = -1;
      r.largest = -1;
      for (int i = 0; i < model_count; i++) begin
         slot_i = (model_head + i) % DEPTH;
         seen = 1'b0;
         for (int j = 0; j < i; j++) begin
            slot_j = (model_head + j) % DEPTH;
            if (model_store[slot_j] == model_store[slot_i]) seen = 1'b1;
         end
         if (!seen) r.distinct++;
         if (i == 0 || model_store[slot_i] < r.smallest) r.smallest = model_store[slot_i];
         if (i == 0 || model_store[slot_i] > r.largest) r.largest = model_store[slot_i];
      end
      r.count = 5'(model_count);
      r.total = model_sum;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response", rsp_data.count, 0);
         end else begin
            sqs_pkg::sqs_rsp_type e;
            e = expected_rsp.pop_front();
            if (rsp_data.popped_value !== e.popped_value)
               report_mismatch("popped_value", rsp_data.popped_value, e.popped_value);
            if (rsp_data.status !== e.status)
               report_mismatch("status", rsp_data.status, e.status);
            if (rsp_data.count !== e.count)
               report_mismatch("count", rsp_data.count, e.count);
            if (rsp_data.distinct !== e.distinct)
               report_mismatch("distinct", rsp_data.distinct, e.distinct);
            if (rsp_data.smallest !== e.smallest)
               report_mismatch("smallest", rsp_data.smallest, e.smallest);
            if (rsp_data.largest !== e.largest)
               report_mismatch("largest", rsp_data.largest, e.largest);
            if (rsp_data.total !== e.total)
               report_mismatch("total", rsp_data.total, e.total);
         end
      end
   end

   // receiver stall pattern: random phases of free flow and sparse/dense stalls,
   // plus a long hold-off on request from the stimulus process
   initial begin
      int mode_len;
      int stall_pct;
      int hold_len;
      wait (!reset);
      forever begin
         if (hold_receiver) begin
            hold_len = 3000;
            repeat (hold_len) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
            hold_receiver = 1'b0;
         end
         mode_len = $urandom_range(5, 60);
         stall_pct = $urandom_range(0, 3) * 25;
         repeat (mode_len) begin
            @(posedge clock);
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   int burst_left = 0;

   // offer one request, predicting at acceptance; bursts and gaps around it
   task automatic send_request(sqs_pkg::sqs_req_type req);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp.push_back(predict_stack_queue(req));
      burst_left--;
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic mode);
      csr_write_enable <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_queue_mode = mode;
   endtask

   function automatic logic signed [31:0] random_value(int pool);
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2, 3: return $urandom_range(0, pool) - pool / 2;
         default: return $urandom;
      endcase
   endfunction

   directed_row_type directed [$];

   function automatic directed_row_type row(logic op, logic signed [31:0] v,
                                            bit lit = 0,
                                            logic [1:0] st = sqs_pkg::STATUS_OK,
                                            logic [4:0] cnt = 0,
                                            logic signed [31:0] lo = -1);
      directed_row_type d;
      d.mode_write = 1'b0;
      d.mode = 1'b0;
      d.req.operation = op;
      d.req.value = v;
      d.literal = lit;
      d.lit_status = st;
      d.lit_count = cnt;
      d.lit_smallest = lo;
      return d;
   endfunction

   initial begin
      sqs_pkg::sqs_req_type req;
      directed_row_type     d;
      int                   pool;
      int                   seq_len;
      model_head = 0;
      model_count = 0;
      model_sum = '0;
      model_queue_mode = 1'b0;
      for (int i = 0; i < DEPTH; i++) model_store[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pop, extremes, fill to full, full push
      directed.push_back(row(sqs_pkg::OP_POP, 0, 1, sqs_pkg::STATUS_EMPTY, 0, -1));
      directed.push_back(row(sqs_pkg::OP_PUSH, 32'sh8000_0000, 1, sqs_pkg::STATUS_OK, 1,
                             32'sh8000_0000));
      directed.push_back(row(sqs_pkg::OP_PUSH, 32'sh7fff_ffff));
      directed.push_back(row(sqs_pkg::OP_PUSH, 32'sh7fff_ffff));
      directed.push_back(row(sqs_pkg::OP_POP, 32'shffff_ffff));
      for (int i = 0; i < DEPTH - 2; i++) directed.push_back(row(sqs_pkg::OP_PUSH, -i));
      directed.push_back(row(sqs_pkg::OP_PUSH, 5, 1, sqs_pkg::STATUS_FULL, 16,
                             32'sh8000_0000));
      foreach (directed[i]) begin
         d = directed[i];
         if (d.literal) begin
            sqs_pkg::sqs_rsp_type e;
            send_request(d.req);
            e = expected_rsp[$];
            if (e.status !== d.lit_status || e.count !== d.lit_count ||
                e.smallest !== d.lit_smallest)
               report_mismatch("directed table row", i, e.status);
         end else begin
            send_request(d.req);
         end
      end
      // mode change while holding data: queue mode pushes at tail
      drain_all();
      write_mode(1'b1);
      for (int i = 0; i < 3; i++) send_request('{sqs_pkg::OP_POP, 0});
      send_request('{sqs_pkg::OP_PUSH, 32'sd77});
      for (int i = 0; i < DEPTH + 1; i++) send_request('{sqs_pkg::OP_POP, 0});

      // long receiver hold-off while the sender keeps offering
      drain_all();
      hold_receiver = 1'b1;
      for (int i = 0; i < 40; i++) send_request('{1'($urandom_range(0, 2) == 0), $urandom});
      drain_all();
      write_mode(1'b0);

      // random part: phases of each mode, fill-then-drain sequences with
      // narrow value pools for repeats, and mixed noise
      for (int n = 0; n < RANDOM_REQUESTS; ) begin
         if ($urandom_range(0, 9) == 0) begin
            drain_all();
            write_mode(1'($urandom_range(0, 1)));
         end
         pool = ($urandom_range(0, 1)) ? 4 : 1000;
         seq_len = $urandom_range(1, DEPTH + 3);
         for (int i = 0; i < seq_len; i++, n++) begin
            req.operation = sqs_pkg::OP_PUSH;
            req.value = random_value(pool);
            send_request(req);
         end
         seq_len = $urandom_range(1, DEPTH + 3);
         for (int i = 0; i < seq_len; i++, n++) begin
            req.operation = ($urandom_range(0, 3) == 0) ? sqs_pkg::OP_PUSH : sqs_pkg::OP_POP;
            req.value = $urandom;
            send_request(req);
         end
      end
      drain_all();
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
